### hdl/aaq_pkg.sv
// Shared constants, types and helpers for the rotation-vector to quaternion pipeline.
package aaq_pkg;

    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;
    localparam int IN_SHR  = (IN_W >= 32) ? IN_W - 32 : 0;
    localparam int IN_SHL  = (IN_W < 32) ? 32 - IN_W : 0;
    localparam int OUT_SHL = (OUT_W >= 32) ? OUT_W - 32 : 0;
    localparam int OUT_SHR = (OUT_W < 32) ? 32 - OUT_W : 0;

    localparam int LANES     = 3;
    localparam int CW        = 34;       // CORDIC x/y and quaternion part width
    localparam int ZW        = 33;       // CORDIC angle accumulator width
    localparam int RW        = 36;       // range reduction width
    localparam int PW        = CW + 32;  // sin * component product width
    localparam int QW        = 33;       // signed quotient width
    localparam int SQ_STEPS  = 32;
    localparam int ROT_STEPS = 30;
    localparam int DIV_STEPS = 32;

    localparam logic [63:0]          SMALL_LIMIT  = 64'd1801440;
    localparam logic signed [RW-1:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [RW-1:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [RW-1:0] TWO_PI_Q30   = 36'sd6746518852;
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [CW-1:0] SAT_MAX      = 34'sd2147483647;
    localparam logic signed [CW-1:0] SAT_MIN      = -34'sd2147483648;

    typedef struct packed {
        logic                   series;
        logic [LANES-1:0][31:0] c;
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        logic [31:0] ang;
        logic        flip;
    } cside_t;

    typedef struct packed {
        tag_t                   tag;
        logic signed [CW-1:0]   qw;
    } dside_t;

    // atan(2^-i) in Q.30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] t;
        case (i)
            0:       t = 33'sd843314857;
            1:       t = 33'sd497837829;
            2:       t = 33'sd263043837;
            3:       t = 33'sd133525159;
            4:       t = 33'sd67021687;
            5:       t = 33'sd33543516;
            6:       t = 33'sd16775851;
            7:       t = 33'sd8388437;
            8:       t = 33'sd4194283;
            9:       t = 33'sd2097149;
            10:      t = 33'sd1048576;
            default: t = ZW'(1) <<< (30 - i);
        endcase
        return t;
    endfunction

    // bring an input component to Q4.27 in 32 bits, floor on the way down
    function automatic logic signed [31:0] to_q27(input logic signed [IN_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        w = (w >>> IN_SHR) <<< IN_SHL;
        return w[31:0];
    endfunction

    // clamp to Q1.30 and scale to the output width
    function automatic logic [OUT_W-1:0] to_out(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic signed [63:0]   w;
        if (v > SAT_MAX) begin
            s = SAT_MAX;
        end else if (v < SAT_MIN) begin
            s = SAT_MIN;
        end else begin
            s = v;
        end
        w = 64'(s);
        w = (w <<< OUT_SHL) >>> OUT_SHR;
        return w[OUT_W-1:0];
    endfunction

endpackage

### hdl/aaq_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module aaq_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         in_rad,
    input  aaq_pkg::tag_t       in_tag,
    output logic                out_valid,
    output logic [31:0]         out_root,
    output aaq_pkg::tag_t       out_tag
);
    import aaq_pkg::*;

    logic        valid_reg [SQ_STEPS];
    logic [63:0] n_reg     [SQ_STEPS];
    logic [63:0] r_reg     [SQ_STEPS];
    tag_t        tag_reg   [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] n_in;
        logic [63:0] r_in;
        logic [63:0] trial;
        logic [63:0] n_next;
        logic [63:0] r_next;
        logic        v_in;
        tag_t        t_in;

        if (j == 0) begin : g_first
            assign n_in = in_rad;
            assign r_in = '0;
            assign v_in = in_valid;
            assign t_in = in_tag;
        end else begin : g_rest
            assign n_in = n_reg[j-1];
            assign r_in = r_reg[j-1];
            assign v_in = valid_reg[j-1];
            assign t_in = tag_reg[j-1];
        end

        assign trial = r_in + BIT;

        always_comb begin
            if (n_in >= trial) begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + BIT;
            end else begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[j]   <= n_next;
                r_reg[j]   <= r_next;
                tag_reg[j] <= t_in;
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign out_root  = r_reg[SQ_STEPS-1][31:0];
    assign out_tag   = tag_reg[SQ_STEPS-1];

endmodule

### hdl/aaq_cordic.sv
// Half-angle range reduction and pipelined rotation-mode CORDIC for sine and cosine.
module aaq_cordic (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [31:0]                     in_ang,
    input  aaq_pkg::tag_t                   in_tag,
    output logic                            out_valid,
    output logic signed [aaq_pkg::CW-1:0]   out_x,
    output logic signed [aaq_pkg::CW-1:0]   out_y,
    output aaq_pkg::cside_t                 out_side
);
    import aaq_pkg::*;

    logic signed [RW-1:0] h;
    logic signed [RW-1:0] r1_next;
    logic signed [RW-1:0] r2_next;
    logic signed [RW-1:0] r3;
    logic signed [RW-1:0] r1_reg;
    logic signed [RW-1:0] r2_reg;
    logic signed [ZW-1:0] z3_reg;
    logic                 flip3;
    logic                 p1_valid_reg;
    logic                 p2_valid_reg;
    logic                 p3_valid_reg;
    cside_t               p1_side_reg;
    cside_t               p2_side_reg;
    cside_t               p3_side_reg;

    logic                 valid_reg [ROT_STEPS];
    logic signed [CW-1:0] x_reg     [ROT_STEPS];
    logic signed [CW-1:0] y_reg     [ROT_STEPS];
    logic signed [ZW-1:0] z_reg     [ROT_STEPS];
    cside_t               side_reg  [ROT_STEPS];

    // h = angle/2 in Q.30; two turns of 2*pi cover the whole input range
    assign h       = RW'({in_ang, 2'b00});
    assign r1_next = (h >= PI_Q30) ? h - TWO_PI_Q30 : h;
    assign r2_next = (r1_reg >= PI_Q30) ? r1_reg - TWO_PI_Q30 : r1_reg;

    // mirror about +-pi/2 into [-pi/2, pi/2]; cosine changes sign
    always_comb begin
        flip3 = 1'b1;
        if (r2_reg > HALF_PI_Q30) begin
            r3 = PI_Q30 - r2_reg;
        end else if (r2_reg < -HALF_PI_Q30) begin
            r3 = -PI_Q30 - r2_reg;
        end else begin
            r3    = r2_reg;
            flip3 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            z3_reg      <= ZW'(r3);
            p1_side_reg <= '{tag: in_tag, ang: in_ang, flip: 1'b0};
            p2_side_reg <= p1_side_reg;
            p3_side_reg <= '{tag: p2_side_reg.tag, ang: p2_side_reg.ang, flip: flip3};
        end
    end

    for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
        localparam logic signed [ZW-1:0] ATAN = atan_q30(k);
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic                 v_in;
        cside_t               s_in;

        if (k == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = z3_reg;
            assign v_in = p3_valid_reg;
            assign s_in = p3_side_reg;
        end else begin : g_rest
            assign x_in = x_reg[k-1];
            assign y_in = y_reg[k-1];
            assign z_in = z_reg[k-1];
            assign v_in = valid_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= s_in;
                if (z_in >= 0) begin
                    x_reg[k] <= x_in - dx;
                    y_reg[k] <= y_in + dy;
                    z_reg[k] <= z_in - ATAN;
                end else begin
                    x_reg[k] <= x_in + dx;
                    y_reg[k] <= y_in - dy;
                    z_reg[k] <= z_in + ATAN;
                end
            end
        end
    end

    assign out_valid = valid_reg[ROT_STEPS-1];
    assign out_x     = x_reg[ROT_STEPS-1];
    assign out_y     = y_reg[ROT_STEPS-1];
    assign out_side  = side_reg[ROT_STEPS-1];

`ifndef SYNTHESIS
    a_angle_converged: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ROT_STEPS-1] |->
            (z_reg[ROT_STEPS-1] >= -ZW'(16) && z_reg[ROT_STEPS-1] <= ZW'(16)))
        else $error("cordic residual angle did not converge");
`endif

endmodule

### hdl/aaq_div.sv
// Three-lane pipelined restoring divider, quotient truncated toward zero.
module aaq_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [aaq_pkg::PW-1:0]   in_num [aaq_pkg::LANES],
    input  logic [31:0]                     in_den,
    input  aaq_pkg::dside_t                 in_side,
    output logic                            out_valid,
    output logic signed [aaq_pkg::QW-1:0]   out_quo [aaq_pkg::LANES],
    output aaq_pkg::dside_t                 out_side
);
    import aaq_pkg::*;

    logic             pre_valid_reg;
    logic [63:0]      pre_rem_reg [LANES];
    logic [LANES-1:0] pre_neg_reg;
    logic [31:0]      pre_den_reg;
    dside_t           pre_side_reg;

    logic             valid_reg [DIV_STEPS];
    logic [63:0]      rem_reg   [DIV_STEPS][LANES];
    logic [31:0]      quo_reg   [DIV_STEPS][LANES];
    logic [LANES-1:0] neg_reg   [DIV_STEPS];
    logic [31:0]      den_reg   [DIV_STEPS];
    dside_t           side_reg  [DIV_STEPS];

    // split off the sign and divide magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                pre_rem_reg[l] <= in_num[l][PW-1] ? 64'(-in_num[l]) : 64'(in_num[l]);
                pre_neg_reg[l] <= in_num[l][PW-1];
            end
            pre_den_reg  <= in_den;
            pre_side_reg <= in_side;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int K = DIV_STEPS - 1 - s;
        logic [63:0]      rem_in  [LANES];
        logic [31:0]      quo_in  [LANES];
        logic [63:0]      rem_next[LANES];
        logic [31:0]      quo_next[LANES];
        logic [63:0]      sh;
        logic [LANES-1:0] neg_in;
        logic [31:0]      den_in;
        logic             v_in;
        dside_t           sd_in;

        if (s == 0) begin : g_first
            assign rem_in = pre_rem_reg;
            assign quo_in = '{default: '0};
            assign neg_in = pre_neg_reg;
            assign den_in = pre_den_reg;
            assign v_in   = pre_valid_reg;
            assign sd_in  = pre_side_reg;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign neg_in = neg_reg[s-1];
            assign den_in = den_reg[s-1];
            assign v_in   = valid_reg[s-1];
            assign sd_in  = side_reg[s-1];
        end

        assign sh = 64'(den_in) << K;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (rem_in[l] >= sh) begin
                    rem_next[l] = rem_in[l] - sh;
                    quo_next[l] = quo_in[l] | (32'd1 << K);
                end else begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                neg_reg[s]  <= neg_in;
                den_reg[s]  <= den_in;
                side_reg[s] <= sd_in;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_sign
        assign out_quo[l] = neg_reg[DIV_STEPS-1][l]
                          ? -$signed({1'b0, quo_reg[DIV_STEPS-1][l]})
                          : $signed({1'b0, quo_reg[DIV_STEPS-1][l]});
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

`ifndef SYNTHESIS
    for (genvar l = 0; l < LANES; l++) begin : g_chk
        a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
            (valid_reg[DIV_STEPS-1] && den_reg[DIV_STEPS-1] != 32'd0) |->
                (rem_reg[DIV_STEPS-1][l] < 64'(den_reg[DIV_STEPS-1])))
            else $error("divider remainder not below divisor");
    end
`endif

endmodule

### hdl/angle_axis_to_quaternion.sv
// Rotation vector (Q4.27) to unit quaternion (Q1.30): top level pipeline.
//
// Takes one rotation vector per clock while not held and returns its unit
// quaternion, one result per clock in steady state. The pipeline is made of
// the input, squaring and sum stages (3), the 32-stage square root, 3 stages of
// half-angle reduction, the 30-stage CORDIC, one multiply stage, the 33-stage
// divider and the output register. The whole pipeline advances together: it
// holds while a result sits in the output register and m_ready is low, and
// s_ready follows from that. Small angles (squared angle below 1e-10) bypass the
// trigonometry and use the series form; all parts saturate to the Q1.30 range.
module angle_axis_to_quaternion (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [aaq_pkg::IN_W-1:0]     s_rx,
    input  logic signed [aaq_pkg::IN_W-1:0]     s_ry,
    input  logic signed [aaq_pkg::IN_W-1:0]     s_rz,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [aaq_pkg::OUT_W-1:0]    m_qw,
    output logic signed [aaq_pkg::OUT_W-1:0]    m_qx,
    output logic signed [aaq_pkg::OUT_W-1:0]    m_qy,
    output logic signed [aaq_pkg::OUT_W-1:0]    m_qz
);
    import aaq_pkg::*;

    logic                 en;

    logic                 a_valid_reg;
    tag_t                 a_tag_reg;

    logic [31:0]          b_mag [LANES];
    logic                 b_valid_reg;
    logic [63:0]          b_sq_reg [LANES];
    tag_t                 b_tag_reg;

    logic [63:0]          c_a2;
    logic                 c_valid_reg;
    logic [63:0]          c_a2_reg;
    tag_t                 c_tag_reg;

    logic                 sq_valid;
    logic [31:0]          sq_root;
    tag_t                 sq_tag;

    logic                 cr_valid;
    logic signed [CW-1:0] cr_x;
    logic signed [CW-1:0] cr_y;
    cside_t               cr_side;

    logic                 mul_valid_reg;
    logic signed [PW-1:0] mul_num_reg [LANES];
    logic [31:0]          mul_den_reg;
    dside_t               mul_side_reg;

    logic                 dv_valid;
    logic signed [QW-1:0] dv_quo [LANES];
    dside_t               dv_side;

    logic signed [CW-1:0] o_part [LANES+1];
    logic                 o_valid_reg;
    logic [OUT_W-1:0]     o_q_reg [LANES+1];

    assign en      = !o_valid_reg || m_ready;
    assign s_ready = en;

    // input register, components in Q4.27
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tag_reg.series <= 1'b0;
            a_tag_reg.c[0]   <= to_q27(s_rx);
            a_tag_reg.c[1]   <= to_q27(s_ry);
            a_tag_reg.c[2]   <= to_q27(s_rz);
        end
    end

    // squares of the magnitudes
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            b_mag[l] = a_tag_reg.c[l][31] ? (~a_tag_reg.c[l] + 32'd1) : a_tag_reg.c[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign c_a2 = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                b_sq_reg[l] <= 64'(b_mag[l]) * 64'(b_mag[l]);
            end
            b_tag_reg <= a_tag_reg;
            c_a2_reg  <= c_a2;
            c_tag_reg <= '{series: (c_a2 < SMALL_LIMIT), c: b_tag_reg.c};
        end
    end

    aaq_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_rad    (c_a2_reg),
        .in_tag    (c_tag_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    aaq_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_ang    (sq_root),
        .in_tag    (sq_tag),
        .out_valid (cr_valid),
        .out_x     (cr_x),
        .out_y     (cr_y),
        .out_side  (cr_side)
    );

    // sin(a/2) times each component, cosine sign fix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= cr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                mul_num_reg[l] <= cr_y * $signed(cr_side.tag.c[l]);
            end
            mul_den_reg      <= cr_side.ang;
            mul_side_reg.tag <= cr_side.tag;
            mul_side_reg.qw  <= cr_side.flip ? -cr_x : cr_x;
        end
    end

    aaq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mul_valid_reg),
        .in_num    (mul_num_reg),
        .in_den    (mul_den_reg),
        .in_side   (mul_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // below the small-angle limit the a^2 series terms are under one LSB,
    // so w is exactly one and the vector part is r/2
    always_comb begin
        if (dv_side.tag.series) begin
            o_part[0] = ONE_Q30;
            for (int l = 0; l < LANES; l++) begin
                o_part[l+1] = CW'($signed(dv_side.tag.c[l])) <<< 2;
            end
        end else begin
            o_part[0] = dv_side.qw;
            for (int l = 0; l < LANES; l++) begin
                o_part[l+1] = CW'(dv_quo[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p <= LANES; p++) begin
                o_q_reg[p] <= to_out(o_part[p]);
            end
        end
    end

    assign m_valid = o_valid_reg;
    assign m_qw    = o_q_reg[0];
    assign m_qx    = o_q_reg[1];
    assign m_qy    = o_q_reg[2];
    assign m_qz    = o_q_reg[3];

`ifndef SYNTHESIS
    localparam int NW = 2 * OUT_W + 4;
    localparam logic signed [NW-1:0] NORM_ONE = NW'(1) <<< (2 * OUT_W - 4);
    localparam logic signed [NW-1:0] NORM_TOL = NW'(1) <<< (2 * OUT_W - 12);
    logic signed [NW-1:0] norm_chk;
    assign norm_chk = NW'(m_qw) * NW'(m_qw) + NW'(m_qx) * NW'(m_qx)
                    + NW'(m_qy) * NW'(m_qy) + NW'(m_qz) * NW'(m_qz);
    a_unit_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((norm_chk - NORM_ONE < NORM_TOL) && (NORM_ONE - norm_chk < NORM_TOL)))
        else $error("result quaternion is not of unit length");
`endif

endmodule
